@@ src/necir_pkg.sv @@
`default_nettype none
package necir_pkg;

  localparam int CODE_BITS_DEF = 32;
  localparam int LEN_W         = 18;
  localparam int KEY_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_KEYS      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_FRAME_GAP    = 3'd5
  } cfg_reg_t;

  localparam logic [LEN_W-1:0] LEADER_MARK_RST  = 18'd9000;
  localparam logic [LEN_W-1:0] LEADER_SPACE_RST = 18'd4500;
  localparam logic [LEN_W-1:0] BIT_MARK_RST     = 18'd500;
  localparam logic [LEN_W-1:0] ZERO_SPACE_RST   = 18'd500;
  localparam logic [LEN_W-1:0] ONE_SPACE_RST    = 18'd1620;
  localparam logic [LEN_W-1:0] FRAME_GAP_RST    = 18'd100000;

  typedef struct packed {
    logic [LEN_W-1:0] leader_mark;
    logic [LEN_W-1:0] leader_space;
    logic [LEN_W-1:0] bit_mark;
    logic [LEN_W-1:0] zero_space;
    logic [LEN_W-1:0] one_space;
    logic [LEN_W-1:0] frame_gap;
  } timing_t;

  typedef struct packed {
    logic pin_level;
    logic frame_start;
    logic key_error;
  } result_t;

  typedef struct packed {
    logic        found;
    logic [31:0] code;
  } lookup_t;

  localparam logic [KEY_W-1:0] KEY_IDS [0:NUM_KEYS-1] = '{
    6'd10, 6'd11, 6'd12, 6'd15, 6'd17, 6'd19,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd36
  };

  localparam logic [31:0] KEY_CODES [0:NUM_KEYS-1] = '{
    32'h404015ea, 32'h40401ce3, 32'h4040bf40, 32'h40400af5,
    32'h404037c8, 32'h404040bf, 32'h40400bf4, 32'h40400ef1,
    32'h404010ef, 32'h404011ee, 32'h40400df2, 32'h404016e9
  };

  function automatic lookup_t key_lookup(input logic [KEY_W-1:0] key);
    lookup_t lk;
    lk = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_IDS[i] == key) begin
        lk.found = 1'b1;
        lk.code  = KEY_CODES[i];
      end
    end
    return lk;
  endfunction

  // zero length acts as one tick
  function automatic logic [LEN_W-1:0] len_of(input logic [LEN_W-1:0] v);
    return (v == '0) ? LEN_W'(1) : v;
  endfunction

endpackage
`default_nettype wire

@@ src/necir_fsm.sv @@
`default_nettype none
module necir_fsm
  import necir_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             mode,
  input  wire logic [KEY_W-1:0] key,
  input  wire timing_t          timing,
  output result_t               result
);

  localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

  typedef enum logic [5:0] {
    PH_IDLE        = 6'b000001,
    PH_LEAD_MARK   = 6'b000010,
    PH_LEAD_SPACE  = 6'b000100,
    PH_BIT_MARK    = 6'b001000,
    PH_BIT_SPACE   = 6'b010000,
    PH_GAP         = 6'b100000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [LEN_W-1:0]     tick_r, tick_nxt;
  logic [BIT_W-1:0]     bitpos_r, bitpos_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;

  lookup_t              lk;
  logic [LEN_W-1:0]     phase_len;
  logic [LEN_W:0]       tick_inc;
  logic                 cur_bit;
  logic                 phase_done;
  logic                 last_bit;

  assign lk         = key_lookup(key);
  assign cur_bit    = code_r[BIT_W'(CODE_BITS - 1) - bitpos_r];
  assign last_bit   = (bitpos_r == BIT_W'(CODE_BITS - 1));
  assign tick_inc   = {1'b0, tick_r} + (LEN_W+1)'(1);
  assign phase_done = (tick_inc >= {1'b0, phase_len});

  always_comb begin
    case (phase_r)
      PH_LEAD_MARK:  phase_len = len_of(timing.leader_mark);
      PH_LEAD_SPACE: phase_len = len_of(timing.leader_space);
      PH_BIT_MARK:   phase_len = len_of(timing.bit_mark);
      PH_BIT_SPACE:  phase_len = cur_bit ? len_of(timing.one_space)
                                         : len_of(timing.zero_space);
      default:       phase_len = len_of(timing.frame_gap);
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bitpos_nxt = bitpos_r;
    code_nxt   = code_r;
    result     = '0;
    if (mode) begin
      tick_nxt         = '0;
      bitpos_nxt       = '0;
      code_nxt         = lk.found ? lk.code[CODE_BITS-1:0] : '0;
      phase_nxt        = lk.found ? PH_LEAD_MARK : PH_IDLE;
      result.key_error = ~lk.found;
    end else if (phase_r != PH_IDLE) begin
      result.pin_level   = (phase_r == PH_LEAD_MARK) || (phase_r == PH_BIT_MARK);
      result.frame_start = (phase_r == PH_LEAD_MARK) && (tick_r == '0);
      if (phase_done) begin
        tick_nxt = '0;
        case (phase_r)
          PH_LEAD_MARK: phase_nxt = PH_LEAD_SPACE;
          PH_LEAD_SPACE: begin
            phase_nxt  = PH_BIT_MARK;
            bitpos_nxt = '0;
          end
          PH_BIT_MARK: phase_nxt = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            if (last_bit) begin
              bitpos_nxt = '0;
              phase_nxt  = PH_GAP;
            end else begin
              bitpos_nxt = bitpos_r + BIT_W'(1);
              phase_nxt  = PH_BIT_MARK;
            end
          end
          default: begin
            phase_nxt  = PH_LEAD_MARK;
            bitpos_nxt = '0;
          end
        endcase
      end else begin
        tick_nxt = tick_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bitpos_r <= '0;
      code_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bitpos_r <= bitpos_nxt;
      code_r   <= code_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/nec_ir_frame_transmitter.sv @@
// NEC-style infrared frame transmitter, one microsecond tick per item.
// Input channel (in_valid / in_stall, in_mode, in_key): mode 1 loads a key
// and restarts the frame; mode 0 is one tick of line time. Every item gives
// exactly one result on the output channel (out_valid / out_stall) carrying
// out_pin_level, out_frame_start and out_key_error.
// The result is registered: it appears in the output register on the
// cycle after the item is accepted. Throughput is one item per clock while
// in_stall is low; the timing state machine updates once per accepted item.
// When the receiver stalls, the result holds in the output register and
// in_stall rises only while that register is full and stalled, so a new
// item is taken in the same cycle the old result leaves.
// Timing registers are written through cfg_valid / cfg_ready with
// cfg_index 0..5 (leader mark, leader space, bit mark, zero space, one space,
// frame gap); writes to other indexes are dropped. cfg_ready is always high.
// Synchronous reset (rst_n low) idles the transmitter, clears the code word,
// empties the output register and restores the default timing.
`default_nettype none
module nec_ir_frame_transmitter
  import necir_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_mode,
  input  wire logic [KEY_W-1:0]     in_key,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_pin_level,
  output logic                      out_frame_start,
  output logic                      out_key_error,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data
);

  timing_t timing_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.leader_mark  <= LEADER_MARK_RST;
      timing_r.leader_space <= LEADER_SPACE_RST;
      timing_r.bit_mark     <= BIT_MARK_RST;
      timing_r.zero_space   <= ZERO_SPACE_RST;
      timing_r.one_space    <= ONE_SPACE_RST;
      timing_r.frame_gap    <= FRAME_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEADER_MARK:  timing_r.leader_mark  <= cfg_data;
        REG_LEADER_SPACE: timing_r.leader_space <= cfg_data;
        REG_BIT_MARK:     timing_r.bit_mark     <= cfg_data;
        REG_ZERO_SPACE:   timing_r.zero_space   <= cfg_data;
        REG_ONE_SPACE:    timing_r.one_space    <= cfg_data;
        REG_FRAME_GAP:    timing_r.frame_gap    <= cfg_data;
        default: ;
      endcase
    end
  end

  necir_fsm #(
    .CODE_BITS(CODE_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (accept),
    .mode   (in_mode),
    .key    (in_key),
    .timing (timing_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pin_level   = res_r.pin_level;
  assign out_frame_start = res_r.frame_start;
  assign out_key_error   = res_r.key_error;

endmodule
`default_nettype wire
